### rtl/sliding_window_average_assert.svh
// Assertion macros shared by the sliding window average RTL.
// Both macros sample on the rising edge of clk_i.
`ifndef SLIDING_WINDOW_AVERAGE_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_ASSERT_SVH

// Checked only while the block is out of reset.
`define SWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, including while reset is applied.
`define SWA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Types, sizes and helpers shared by the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

  localparam int unsigned SampleW   = 32;
  localparam int unsigned CfgW      = 9;
  localparam int unsigned WindowMax = 256;
  localparam int unsigned PtrW      = $clog2(WindowMax);
  localparam int unsigned CountW    = $clog2(WindowMax + 1);
  localparam int unsigned DivCntW   = $clog2(SampleW);

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last_sample;
  } swa_in_t;

  typedef struct packed {
    logic [SampleW-1:0] average;
    logic               too_short;
  } swa_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } swa_div_status_t;

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StDivide
  } swa_state_e;

  // A window length of zero acts as one, and anything above the delay line
  // depth acts as the full depth.
  function automatic logic [CountW-1:0] eff_window(input logic [CfgW-1:0] cfg);
    int unsigned w;
    w = int'(cfg);
    if (w == 0) begin
      w = 1;
    end
    if (w > WindowMax) begin
      w = WindowMax;
    end
    return CountW'(w);
  endfunction

endpackage

### rtl/swa_delay_ram.sv
// ----------------------------------------------------------------------------
// swa_delay_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module swa_delay_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/swa_divider.sv
// ----------------------------------------------------------------------------
// swa_divider
// Restoring divider, one quotient bit per cycle, 32-bit dividend by a
// window-sized divisor.
// ----------------------------------------------------------------------------
`include "sliding_window_average_assert.svh"

module swa_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [swa_pkg::SampleW-1:0] dividend_i,
  input  logic [swa_pkg::CountW-1:0]  divisor_i,
  output swa_pkg::swa_div_status_t    status_o,
  output logic [swa_pkg::SampleW-1:0] quotient_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [swa_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [swa_pkg::SampleW-1:0] quo_q, quo_d;
  logic [swa_pkg::CountW-1:0]  rem_q, rem_d;
  logic [swa_pkg::CountW-1:0]  divisor_q, divisor_d;

  logic [swa_pkg::CountW:0]    trial;
  logic                        fits;

  // The remainder stays below the divisor, so the shifted trial value needs
  // only one extra bit.
  assign trial = {rem_q, quo_q[swa_pkg::SampleW-1]};
  assign fits  = trial >= {1'b0, divisor_q};

  always_comb begin
    busy_d    = busy_q;
    done_d    = done_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      done_d    = 1'b0;
      cnt_d     = swa_pkg::DivCntW'(swa_pkg::SampleW - 1);
      quo_d     = dividend_i;
      rem_d     = '0;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[swa_pkg::SampleW-2:0], fits};
      rem_d = fits ? swa_pkg::CountW'(trial - {1'b0, divisor_q})
                   : swa_pkg::CountW'(trial);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - swa_pkg::DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

  `SWA_ASSERT(a_no_restart_busy, !(start_i && busy_q), "divider started while busy")
  `SWA_ASSERT(a_finish, busy_q && !start_i && cnt_q == '0 |=> done_q && !busy_q,
              "divider did not finish after last step")
  `SWA_ASSERT(a_rem_bound, done_q |-> rem_q < divisor_q, "remainder not below divisor")

endmodule

### rtl/sliding_window_average.sv
// ----------------------------------------------------------------------------
// sliding_window_average
// Moving average over a stream of unsigned 32-bit samples.
// ----------------------------------------------------------------------------
// Each accepted sample yields one average: the wrapping 32-bit running sum
// divided, truncating, by the number of samples seen in the sequence until
// the window is full, and by the window length after that. A sample marked
// last closes the sequence; too_short is raised on it if the window never
// filled. Samples are taken one at a time: on acceptance the leaving sample
// is read from the delay line RAM, the update step then updates the sum and
// writes the new sample, the bit-serial divider runs, and the result is
// loaded into the output register once that is free. The output register
// lets the next sample be accepted while a result still waits. The delay
// line RAM is not cleared; only entries written in the current sequence are
// ever used. Write the window length only while the block is idle.
// ----------------------------------------------------------------------------
`include "sliding_window_average_assert.svh"

module sliding_window_average (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [swa_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  swa_pkg::swa_in_t         in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output swa_pkg::swa_out_t        out_o
);

  swa_pkg::swa_state_e state_q, state_d;

  logic [swa_pkg::CfgW-1:0]    window_len_q;
  logic [swa_pkg::CountW-1:0]  seen_q;
  logic [swa_pkg::SampleW-1:0] sum_q;
  logic [swa_pkg::PtrW-1:0]    wp_q;

  logic [swa_pkg::SampleW-1:0] x_q;
  logic                        last_q;
  logic                        sub_q;
  logic [swa_pkg::CountW-1:0]  w_q;
  logic                        too_short_q;

  logic                        out_valid_q;
  swa_pkg::swa_out_t           out_q;

  logic                        accept;
  logic                        ram_re, ram_we, div_start, out_load;
  logic [swa_pkg::CountW-1:0]  w_eff;
  logic [swa_pkg::CountW:0]    old_sum_idx;
  logic [swa_pkg::PtrW-1:0]    old_idx;
  logic [swa_pkg::PtrW-1:0]    wp_next;
  logic [swa_pkg::SampleW-1:0] ram_rdata;
  logic [swa_pkg::SampleW-1:0] sum_new;
  logic [swa_pkg::CountW-1:0]  seen_new;
  logic [swa_pkg::SampleW-1:0] quotient;
  swa_pkg::swa_div_status_t    div_status;

  assign accept = in_valid_i && in_ready_o;
  assign w_eff  = swa_pkg::eff_window(window_len_q);

  // Slot of the sample that leaves the window: w positions behind the
  // write pointer, modulo the delay line depth.
  assign old_sum_idx = (swa_pkg::CountW + 1)'(wp_q)
                       + (swa_pkg::CountW + 1)'(swa_pkg::WindowMax)
                       - {1'b0, w_eff};
  assign old_idx = (old_sum_idx >= (swa_pkg::CountW + 1)'(swa_pkg::WindowMax))
                   ? swa_pkg::PtrW'(old_sum_idx - (swa_pkg::CountW + 1)'(swa_pkg::WindowMax))
                   : swa_pkg::PtrW'(old_sum_idx);

  assign wp_next = (wp_q == swa_pkg::PtrW'(swa_pkg::WindowMax - 1)) ? '0
                   : wp_q + swa_pkg::PtrW'(1);

  assign sum_new  = sum_q + x_q - (sub_q ? ram_rdata : '0);
  assign seen_new = sub_q ? seen_q : seen_q + swa_pkg::CountW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swa_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = swa_pkg::StUpdate;
        end
      end
      swa_pkg::StUpdate: begin
        state_d = swa_pkg::StDivide;
      end
      swa_pkg::StDivide: begin
        if (div_status.done && (!out_valid_q || out_ready_i)) begin
          state_d = swa_pkg::StIdle;
        end
      end
      default: begin
        state_d = swa_pkg::StIdle;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      swa_pkg::StIdle: begin
        in_ready_o = 1'b1;
      end
      swa_pkg::StUpdate: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      swa_pkg::StDivide: begin
        out_load = div_status.done && (!out_valid_q || out_ready_i);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign ram_re = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swa_pkg::StIdle;
      window_len_q <= swa_pkg::CfgW'(1);
      seen_q       <= '0;
      sum_q        <= '0;
      wp_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        window_len_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        sum_q  <= last_q ? '0 : sum_new;
        seen_q <= last_q ? '0 : seen_new;
        wp_q   <= wp_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= in_i.sample;
      last_q <= in_i.last_sample;
      sub_q  <= seen_q >= w_eff;
      w_q    <= w_eff;
    end
    if (ram_we) begin
      too_short_q <= last_q && (seen_new < w_q);
    end
    if (out_load) begin
      out_q.average   <= quotient;
      out_q.too_short <= too_short_q;
    end
  end

  swa_delay_ram #(
    .Depth(swa_pkg::WindowMax),
    .Width(swa_pkg::SampleW)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(x_q),
    .re_i   (ram_re),
    .raddr_i(old_idx),
    .rdata_o(ram_rdata)
  );

  swa_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_new),
    .divisor_i (sub_q ? w_q : seen_new),
    .status_o  (div_status),
    .quotient_o(quotient)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SWA_ASSERT(a_accept_update, accept |=> state_q == swa_pkg::StUpdate,
              "accepted transfer did not move to the update step")
  `SWA_ASSERT(a_update_divides, state_q == swa_pkg::StUpdate |=> div_status.busy,
              "divider not running after the update step")
  `SWA_ASSERT(a_load_valid, out_load |=> out_valid_q, "loaded result not presented")
  `SWA_ASSERT_ALWAYS(a_seen_bound, seen_q <= swa_pkg::CountW'(swa_pkg::WindowMax),
                     "sample count exceeds delay line depth")

endmodule

### tb/average_checker.sv
// ----------------------------------------------------------------------------
// average_checker
// Watches the sample and average channels and checks every average.
// ----------------------------------------------------------------------------
// Keeps its own copy of the window length, the delay line, the running sum
// and the sample count. Each input transfer yields one expected average.
// Each output transfer is compared with the oldest expected average.
// ----------------------------------------------------------------------------
module average_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [swa_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  swa_pkg::swa_in_t         in_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  swa_pkg::swa_out_t        out_i,
  output int unsigned              pending_o,
  output int unsigned              errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [swa_pkg::SampleW-1:0] recent_samples [swa_pkg::WindowMax];
  logic [swa_pkg::SampleW-1:0] running_sum;
  int unsigned                 seen_count;
  logic [swa_pkg::PtrW-1:0]    write_slot;
  logic [swa_pkg::CfgW-1:0]    window_len;
  swa_pkg::swa_out_t           expected_averages [$];
  swa_pkg::swa_out_t           wanted;
  int unsigned                 errors = 0;

  function automatic swa_pkg::swa_out_t predict_average(input swa_pkg::swa_in_t item);
    swa_pkg::swa_out_t        res;
    int unsigned              w;
    int unsigned              divisor;
    logic [swa_pkg::PtrW-1:0] leaving;
    w = window_len;
    if (w == 0) begin
      w = 1;
    end
    if (w > swa_pkg::WindowMax) begin
      w = swa_pkg::WindowMax;
    end
    if (seen_count < w) begin
      running_sum = running_sum + item.sample;
      if (seen_count < swa_pkg::WindowMax) begin
        seen_count++;
      end
      divisor = seen_count;
    end else begin
      // The slot w positions back; a full-depth window lands on this slot.
      leaving = write_slot - swa_pkg::PtrW'(w);
      running_sum = running_sum + item.sample - recent_samples[leaving];
      divisor = w;
    end
    recent_samples[write_slot] = item.sample;
    write_slot = write_slot + swa_pkg::PtrW'(1);
    res.average = running_sum / divisor;
    res.too_short = 1'b0;
    if (item.last_sample) begin
      res.too_short = seen_count < w;
      seen_count = 0;
      running_sum = '0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum = '0;
      seen_count = 0;
      write_slot = '0;
      window_len = swa_pkg::CfgW'(1);
      expected_averages.delete();
      pending_o <= 0;
      errors_o <= errors;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_averages.size() == 0) begin
          $error("unexpected result: average %h too_short %b", out_i.average,
                 out_i.too_short);
          errors++;
        end else begin
          wanted = expected_averages.pop_front();
          if (out_i.average !== wanted.average) begin
            $error("average: expected %h, got %h", wanted.average, out_i.average);
            errors++;
          end
          if (out_i.too_short !== wanted.too_short) begin
            $error("too_short: expected %b, got %b", wanted.too_short, out_i.too_short);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_averages.push_back(predict_average(in_i));
      end
      // Writes only happen while idle, so no transfer shares this edge.
      if (cfg_we_i) begin
        window_len = cfg_wdata_i;
      end
      pending_o <= expected_averages.size();
      errors_o <= errors;
    end
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the sliding window average block.
// ----------------------------------------------------------------------------
// A directed part covers the sample extremes, the window extremes, short
// sequences and a window change inside an open sequence. Random phases then
// write a new window length and send sequences of random samples whose
// lengths cluster around the window. Both channels idle at random; the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemCount = 2000;
  localparam int unsigned IdlePct   = 23;
  localparam int unsigned QuietFrom = 700;
  localparam int unsigned QuietTo   = 1000;
  localparam int unsigned HoldAt    = 300;
  localparam int unsigned HoldLen   = 500;
  localparam int unsigned CycleCap  = 1000000;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [swa_pkg::CfgW-1:0] cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  swa_pkg::swa_in_t         in_item;
  logic                     out_valid;
  logic                     out_ready;
  swa_pkg::swa_out_t        out_item;
  int unsigned              pending;
  int unsigned              errors;
  int unsigned              sent = 0;
  int unsigned              cycles = 0;
  int unsigned              window_now = 1;
  int unsigned              seq_left = 0;

  always #10 clk = ~clk;

  sliding_window_average DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item)
  );

  average_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_i        (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_i       (out_item),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleCap) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off, and a quiet stretch.
  initial begin : receiver
    int unsigned taken;
    int unsigned hold_left;
    bit          held;
    taken = 0;
    hold_left = 0;
    held = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        taken++;
      end
      if (!held && taken >= HoldAt) begin
        held = 1;
        hold_left = HoldLen;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (taken >= QuietFrom && taken < QuietTo) ||
                     ($urandom_range(99) >= IdlePct);
      end
    end
  end

  task automatic send_item(input logic [swa_pkg::SampleW-1:0] value, input logic is_last);
    while (!(sent >= QuietFrom && sent < QuietTo) && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= swa_pkg::swa_in_t'{sample: value, last_sample: is_last};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // The block must be idle for a write, so drain every average first.
  task automatic write_window(input logic [swa_pkg::CfgW-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_now = value;
  endtask

  function automatic logic [swa_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return swa_pkg::SampleW'($urandom_range(255));
      default: return swa_pkg::SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [swa_pkg::CfgW-1:0] pick_window();
    case ($urandom_range(19))
      0:       return '0;
      1:       return swa_pkg::CfgW'(1);
      2:       return swa_pkg::CfgW'(swa_pkg::WindowMax);
      3:       return swa_pkg::CfgW'($urandom_range(swa_pkg::WindowMax + 1, 511));
      4:       return '1;
      5:       return swa_pkg::CfgW'($urandom_range(1, swa_pkg::WindowMax));
      default: return swa_pkg::CfgW'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic int unsigned sequence_length(input int unsigned w);
    case ($urandom_range(5))
      0:       return (w > 1) ? w - 1 : 1;
      1:       return w;
      2:       return w + 1;
      3:       return 1;
      default: return $urandom_range(1, 2 * w + 2);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned w;
    int unsigned phase_len;
    int unsigned random_sent;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_item <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default window of one, including a sum that wraps.
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'h0000_0005, 1'b1);
    // A zero window acts as one.
    write_window('0);
    send_item(32'h0000_0007, 1'b1);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(32'h5555_5555, 1'b1);
    // Short sequence, then a full one, then one left open.
    write_window(swa_pkg::CfgW'(4));
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    for (int unsigned k = 1; k <= 6; k++) begin
      send_item(swa_pkg::SampleW'(k), k == 6);
    end
    send_item(32'd10, 1'b0);
    send_item(32'd20, 1'b0);
    send_item(32'd30, 1'b0);
    // Shrink the window while that sequence is still open.
    write_window(swa_pkg::CfgW'(2));
    send_item(32'd40, 1'b0);
    send_item(32'd50, 1'b1);
    // Full-depth and oversized windows on short sequences.
    write_window(swa_pkg::CfgW'(swa_pkg::WindowMax));
    send_item(32'h1234_5678, 1'b1);
    write_window('1);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0001, 1'b1);

    random_sent = 0;
    while (random_sent < ItemCount) begin
      write_window(pick_window());
      w = window_now;
      if (w == 0) begin
        w = 1;
      end
      if (w > swa_pkg::WindowMax) begin
        w = swa_pkg::WindowMax;
      end
      phase_len = (w > 16) ? $urandom_range(150, 400) : $urandom_range(20, 120);
      // A sequence may stay open across a phase, so the next phase changes
      // the window in the middle of it.
      repeat (phase_len) begin
        if (seq_left == 0) begin
          seq_left = sequence_length(w);
        end
        seq_left--;
        send_item(pick_sample(), seq_left == 0);
        random_sent++;
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/swa_pkg.sv
rtl/swa_delay_ram.sv
rtl/swa_divider.sv
rtl/sliding_window_average.sv
tb/average_checker.sv
tb/testbench.sv
